@@ rtl/trss_pkg.sv @@
// ----------------------------------------------------------------------------
// trss_pkg
// Shared types and constants of the two real spectrum split unit.
// ----------------------------------------------------------------------------
`default_nettype none

package trss_pkg;

   localparam int MAX_BINS_DEFAULT = 1024;

   localparam int BIN_COUNT_W = 11;
   localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET = 11'd1024;

   localparam int DATA_W  = 24;
   localparam int INDEX_W = 10;

   localparam int RESULT_FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_STORE,
      KIND_DC,
      KIND_MID,
      KIND_PAIR
   } kind_type;

   typedef struct packed {
      logic [INDEX_W-1:0]       bin_index;
      logic signed [DATA_W-1:0] first_re;
      logic signed [DATA_W-1:0] first_im;
      logic signed [DATA_W-1:0] second_re;
      logic signed [DATA_W-1:0] second_im;
      logic                     last;
   } result_type;

   // number of result words an item of the given kind produces
   function automatic logic [1:0] result_count(input kind_type kind);
      logic [1:0] n;
      case (kind)
         KIND_STORE: n = 2'd0;
         KIND_DC:    n = 2'd1;
         KIND_MID:   n = 2'd1;
         KIND_PAIR:  n = 2'd2;
         default:    n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

@@ rtl/trss_ram.sv @@
// ----------------------------------------------------------------------------
// trss_ram
// Generic simple dual port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module trss_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/trss_combine.sv @@
// ----------------------------------------------------------------------------
// trss_combine
// Separates one packed bin pair into the bins of the two real channels.
// ----------------------------------------------------------------------------
`default_nettype none

module trss_combine (
   input  wire trss_pkg::kind_type              kind,
   input  wire logic [trss_pkg::INDEX_W-1:0]    bin_k,
   input  wire logic [trss_pkg::INDEX_W-1:0]    bin_m,
   input  wire logic signed [trss_pkg::DATA_W-1:0] a_re,
   input  wire logic signed [trss_pkg::DATA_W-1:0] a_im,
   input  wire logic signed [trss_pkg::DATA_W-1:0] mem_re,
   input  wire logic signed [trss_pkg::DATA_W-1:0] mem_im,
   output trss_pkg::result_type                 result0,
   output trss_pkg::result_type                 result1
);

   import trss_pkg::*;

   logic signed [DATA_W-1:0] b_re;
   logic signed [DATA_W-1:0] b_im;
   logic signed [DATA_W:0]   sum_re;
   logic signed [DATA_W:0]   sum_im;
   logic signed [DATA_W:0]   dif_im_ab;
   logic signed [DATA_W:0]   dif_im_ba;
   logic signed [DATA_W:0]   dif_re_ab;
   logic signed [DATA_W:0]   dif_re_ba;

   always_comb begin
      // the middle bin pairs with itself
      b_re = (kind == KIND_MID) ? a_re : mem_re;
      b_im = (kind == KIND_MID) ? a_im : mem_im;

      sum_re    = {a_re[DATA_W-1], a_re} + {b_re[DATA_W-1], b_re};
      sum_im    = {a_im[DATA_W-1], a_im} + {b_im[DATA_W-1], b_im};
      dif_im_ab = {a_im[DATA_W-1], a_im} - {b_im[DATA_W-1], b_im};
      dif_im_ba = {b_im[DATA_W-1], b_im} - {a_im[DATA_W-1], a_im};
      dif_re_ab = {a_re[DATA_W-1], a_re} - {b_re[DATA_W-1], b_re};
      dif_re_ba = {b_re[DATA_W-1], b_re} - {a_re[DATA_W-1], a_re};

      if (kind == KIND_DC) begin
         result0.bin_index = '0;
         result0.first_re  = a_re;
         result0.first_im  = '0;
         result0.second_re = a_im;
         result0.second_im = '0;
         result0.last      = 1'b1;
      end else begin
         result0.bin_index = bin_k;
         result0.first_re  = sum_re[DATA_W:1];
         result0.first_im  = dif_im_ab[DATA_W:1];
         result0.second_re = sum_im[DATA_W:1];
         result0.second_im = dif_re_ba[DATA_W:1];
         result0.last      = (kind == KIND_MID);
      end

      result1.bin_index = bin_m;
      result1.first_re  = sum_re[DATA_W:1];
      result1.first_im  = dif_im_ba[DATA_W:1];
      result1.second_re = sum_im[DATA_W:1];
      result1.second_im = dif_re_ab[DATA_W:1];
      result1.last      = 1'b1;
   end

endmodule

`default_nettype wire

@@ rtl/trss_result_fifo.sv @@
// ----------------------------------------------------------------------------
// trss_result_fifo
// Small result queue, takes up to two words per cycle, gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module trss_result_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           push_count,
   input  wire trss_pkg::result_type push_data0,
   input  wire trss_pkg::result_type push_data1,
   output logic [$clog2(trss_pkg::RESULT_FIFO_DEPTH+1)-1:0] fill,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output trss_pkg::result_type      out_data
);

   import trss_pkg::*;

   localparam int PtrW = $clog2(RESULT_FIFO_DEPTH);
   localparam int CntW = $clog2(RESULT_FIFO_DEPTH + 1);

   result_type         mem_ff [RESULT_FIFO_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff;
   logic [PtrW-1:0]    wr_ptr_in;
   logic [PtrW-1:0]    wr_ptr_next;
   logic [PtrW-1:0]    rd_ptr_ff;
   logic [PtrW-1:0]    rd_ptr_in;
   logic [CntW-1:0]    count_ff;
   logic [CntW-1:0]    count_in;
   logic               pop;

   always_comb begin
      pop         = out_valid && out_ready;
      wr_ptr_next = wr_ptr_ff + PtrW'(1);
      wr_ptr_in   = wr_ptr_ff + PtrW'(push_count);
      rd_ptr_in   = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in    = count_ff + CntW'(push_count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_data1;
      end
   end

   assign fill      = count_ff;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ rtl/two_real_spectrum_split_unit.sv @@
// ----------------------------------------------------------------------------
// two_real_spectrum_split_unit
// Splits the packed spectrum of two real channels into the two spectra.
// ----------------------------------------------------------------------------
// Bins arrive one word per item in index order. Bins of the first half of a
// frame go into a synchronous store and give no result; bin 0 gives its result
// at once; the middle bin gives one result alone; each later bin reads its
// mirror bin from the store and gives bin k then bin size-k. Bins are taken
// one per cycle while the result queue has room; the two results of a later
// bin share the single result port. A result passes the s1 register and the
// result queue to rsp; the four-word queue lets input go on while rsp stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module two_real_spectrum_split_unit #(
   parameter int MAX_BINS = trss_pkg::MAX_BINS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [trss_pkg::DATA_W-1:0]    req_bin_re,
   input  wire logic signed [trss_pkg::DATA_W-1:0]    req_bin_im,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [trss_pkg::INDEX_W-1:0]               rsp_bin_index,
   output logic signed [trss_pkg::DATA_W-1:0]         rsp_first_re,
   output logic signed [trss_pkg::DATA_W-1:0]         rsp_first_im,
   output logic signed [trss_pkg::DATA_W-1:0]         rsp_second_re,
   output logic signed [trss_pkg::DATA_W-1:0]         rsp_second_im,
   output logic                                       rsp_last,
   input  wire logic                                  csr_write_enable,
   input  wire logic [trss_pkg::BIN_COUNT_W-1:0]      csr_write_data
);

   import trss_pkg::*;

   localparam int CntW       = $clog2(MAX_BINS);
   localparam int SizeW      = $clog2(MAX_BINS + 1);
   localparam int DblW       = SizeW + 1;
   localparam int CmpW       = (SizeW > BIN_COUNT_W) ? SizeW : BIN_COUNT_W;
   localparam int StoreDepth = MAX_BINS / 2;
   localparam int StoreAw    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
   localparam int FillW      = $clog2(RESULT_FIFO_DEPTH + 1);
   localparam int SumW       = FillW + 1;

   logic [BIN_COUNT_W-1:0]   bin_count_ff;
   logic [CntW-1:0]          bin_counter_ff;
   logic [CntW-1:0]          bin_counter_in;

   logic                     s1_valid_ff;
   kind_type                 s1_kind_ff;
   logic [INDEX_W-1:0]       s1_k_ff;
   logic [INDEX_W-1:0]       s1_m_ff;
   logic signed [DATA_W-1:0] s1_re_ff;
   logic signed [DATA_W-1:0] s1_im_ff;

   logic                     accept;
   logic [CmpW-1:0]          count_ext;
   logic [SizeW-1:0]         size;
   logic [CntW-1:0]          k_eff;
   logic [DblW-1:0]          k_twice;
   logic [SizeW-1:0]         m_full;
   logic [SizeW-1:0]         k_next;
   kind_type                 kind;

   logic [2*DATA_W-1:0]      mem_rd_data;
   logic                     mem_wr_en;
   logic                     mem_rd_en;

   logic [1:0]               push_count;
   logic [FillW-1:0]         fill;
   result_type               result0;
   result_type               result1;
   result_type               out_data;

   // frame position and item kind
   always_comb begin
      count_ext = CmpW'(bin_count_ff);
      if (count_ext == '0) begin
         size = SizeW'(1);
      end else if (count_ext > CmpW'(MAX_BINS)) begin
         size = SizeW'(MAX_BINS);
      end else begin
         size = SizeW'(count_ext);
      end

      k_eff   = (SizeW'(bin_counter_ff) >= size) ? '0 : bin_counter_ff;
      k_twice = DblW'({k_eff, 1'b0});
      m_full  = size - SizeW'(k_eff);
      k_next  = SizeW'(k_eff) + SizeW'(1);

      if (k_eff == '0) begin
         kind = KIND_DC;
      end else if (k_twice < DblW'(size)) begin
         kind = KIND_STORE;
      end else if (k_twice == DblW'(size)) begin
         kind = KIND_MID;
      end else begin
         kind = KIND_PAIR;
      end
   end

   // queue room for whatever is in flight plus a pair
   always_comb begin
      push_count = s1_valid_ff ? result_count(s1_kind_ff) : 2'd0;
      req_ready  = (SumW'(fill) + SumW'(push_count)) <= SumW'(RESULT_FIFO_DEPTH - 2);
      accept     = req_valid && req_ready;
      mem_wr_en  = accept && (kind == KIND_STORE);
      mem_rd_en  = accept && (kind == KIND_PAIR);

      if (accept) begin
         bin_counter_in = (k_next >= size) ? '0 : CntW'(k_next);
      end else begin
         bin_counter_in = bin_counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff   <= BIN_COUNT_RESET;
         bin_counter_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            bin_count_ff <= csr_write_data;
         end
         bin_counter_ff <= bin_counter_in;
         s1_valid_ff    <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= kind;
         s1_k_ff    <= INDEX_W'(k_eff);
         s1_m_ff    <= INDEX_W'(m_full);
         s1_re_ff   <= req_bin_re;
         s1_im_ff   <= req_bin_im;
      end
   end

   trss_ram #(
      .WIDTH  (2 * DATA_W),
      .DEPTH  (StoreDepth),
      .ADDR_W (StoreAw)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (StoreAw'(k_eff)),
      .wr_data ({req_bin_re, req_bin_im}),
      .rd_en   (mem_rd_en),
      .rd_addr (StoreAw'(m_full)),
      .rd_data (mem_rd_data)
   );

   trss_combine u_combine (
      .kind    (s1_kind_ff),
      .bin_k   (s1_k_ff),
      .bin_m   (s1_m_ff),
      .a_re    (s1_re_ff),
      .a_im    (s1_im_ff),
      .mem_re  (mem_rd_data[2*DATA_W-1:DATA_W]),
      .mem_im  (mem_rd_data[DATA_W-1:0]),
      .result0 (result0),
      .result1 (result1)
   );

   trss_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (result0),
      .push_data1 (result1),
      .fill       (fill),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_bin_index = out_data.bin_index;
   assign rsp_first_re  = out_data.first_re;
   assign rsp_first_im  = out_data.first_im;
   assign rsp_second_re = out_data.second_re;
   assign rsp_second_im = out_data.second_im;
   assign rsp_last      = out_data.last;

endmodule

`default_nettype wire

@@ rtl/trss_checker.sv @@
// ----------------------------------------------------------------------------
// trss_checker
// Port level checks of the two real spectrum split unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module trss_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [trss_pkg::INDEX_W-1:0]       rsp_bin_index,
   input wire logic signed [trss_pkg::DATA_W-1:0] rsp_first_re,
   input wire logic signed [trss_pkg::DATA_W-1:0] rsp_first_im,
   input wire logic signed [trss_pkg::DATA_W-1:0] rsp_second_re,
   input wire logic signed [trss_pkg::DATA_W-1:0] rsp_second_im,
   input wire logic                               rsp_last
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index)
         && $stable(rsp_first_re) && $stable(rsp_first_im)
         && $stable(rsp_second_re) && $stable(rsp_second_im) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // nothing left over after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // the second word of a pair is queued with the first
   a_pair_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("second word of a pair missing");

   // a pair has exactly two words
   a_pair_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_last)
      else $error("pair not closed by last");

endmodule

bind two_real_spectrum_split_unit trss_checker u_trss_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_bin_index (rsp_bin_index),
   .rsp_first_re  (rsp_first_re),
   .rsp_first_im  (rsp_first_im),
   .rsp_second_re (rsp_second_re),
   .rsp_second_im (rsp_second_im),
   .rsp_last      (rsp_last)
);

`default_nettype wire
